[rtl/core/fipa_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fipa_pkg
// Shared types and constants of the free identifier pool allocator: beat
// payloads, command codes, controller states and the bitmap write group.
// ----------------------------------------------------------------------------
package fipa_pkg;

  localparam int ID_W  = 8;
  localparam int CNT_W = 9;
  localparam int ID_SPACE = 1 << ID_W;

  typedef logic [1:0] fipa_cmd_t;

  localparam fipa_cmd_t CMD_ALLOC   = 2'd0;
  localparam fipa_cmd_t CMD_RELEASE = 2'd1;
  localparam fipa_cmd_t CMD_REINIT  = 2'd2;

  typedef struct packed {
    fipa_cmd_t         command;
    logic [ID_W-1:0]   id_in;
  } fipa_in_t;

  typedef struct packed {
    logic              alloc_valid;
    logic [ID_W-1:0]   alloc_id;
    logic              release_accepted;
    logic [CNT_W-1:0]  free_left;
  } fipa_out_t;

  typedef struct packed {
    logic              wr_en;
    logic [ID_W-1:0]   wr_id;
    logic              wr_bit;
  } fipa_bm_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ALLOC_RD,
    ST_REL_CHK,
    ST_INIT,
    ST_WIPE
  } fipa_state_t;

endpackage : fipa_pkg
`default_nettype wire

[rtl/core/fipa_ring.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fipa_ring
// Identifier queue storage: one write port and one read port, with the read
// data registered. Contents are undefined until written.
// ----------------------------------------------------------------------------
module fipa_ring #(
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                    clk,
  input  wire logic                    we,
  input  wire logic [AW-1:0]           waddr,
  input  wire logic [fipa_pkg::ID_W-1:0] wdata,
  input  wire logic                    re,
  input  wire logic [AW-1:0]           raddr,
  output logic [fipa_pkg::ID_W-1:0]    rdata
);
  import fipa_pkg::*;

  logic [ID_W-1:0] ring_mem [DEPTH];
  logic [ID_W-1:0] rd_data_r;

  // Write the queued identifier
  always_ff @(posedge clk) begin
    if (we) begin
      ring_mem[waddr] <= wdata;
    end
  end

  // Register the read data
  always_ff @(posedge clk) begin
    if (re) begin
      rd_data_r <= ring_mem[raddr];
    end
  end

  assign rdata = rd_data_r;

endmodule : fipa_ring
`default_nettype wire

[rtl/core/fipa_bitmap.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fipa_bitmap
// Presence bitmap: one flag per identifier, set while that identifier sits
// in the pool. One write port and one registered read port; contents are
// not reset, the controller sweeps every flag after reset and on reinitialize.
// ----------------------------------------------------------------------------
module fipa_bitmap (
  input  wire logic                      clk,
  input  wire fipa_pkg::fipa_bm_ctrl_t   ctrl,
  input  wire logic                      rd_en,
  input  wire logic [fipa_pkg::ID_W-1:0] rd_id,
  output logic                           rd_hit
);
  import fipa_pkg::*;

  logic present_mem [ID_SPACE];
  logic rd_hit_r;

  // Write one flag
  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      present_mem[ctrl.wr_id] <= ctrl.wr_bit;
    end
  end

  // Register the looked-up flag
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_hit_r <= present_mem[rd_id];
    end
  end

  assign rd_hit = rd_hit_r;

endmodule : fipa_bitmap
`default_nettype wire

[rtl/core/free_id_pool_allocator.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// free_id_pool_allocator
// Pool of free identifiers handed out in first-in, first-out order.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats (in_data) carry a command: allocate, release id_in, or
//   reinitialize. Each input beat yields exactly one output beat (out_data)
//   with the allocated identifier, the release outcome and the free count.
//   cfg_we/cfg_wdata set pool_size, the count loaded by reinitialize; write
//   it only while the block is idle.
//   Unused codes and allocate from an empty pool register the output beat
//   at accept; allocate and release first pass ALLOC_RD or REL_CHK for the
//   registered reads of the identifier ring and the presence bitmap;
//   reinitialize passes INIT, which sweeps all 256 bitmap flags one a
//   cycle and fills the ring with the first n = min(pool_size, MAX_IDS, 256).
//   One item is in flight at a time; the next beat is accepted at the
//   earliest in the cycle in which the previous result is taken.
//   Reset empties the pool (pointers and count cleared) and sets pool_size
//   to 256, then a sweep of all 256 flags clears the bitmap with in_ready low.
//   A stalled receiver holds the output register, and in_ready stays low
//   until that beat is taken.
// ----------------------------------------------------------------------------
module free_id_pool_allocator #(
  parameter int MAX_IDS = 256
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire fipa_pkg::fipa_in_t          in_data,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output fipa_pkg::fipa_out_t              out_data,
  input  wire logic                        cfg_we,
  input  wire logic [fipa_pkg::CNT_W-1:0]  cfg_wdata
);
  import fipa_pkg::*;

  localparam int PTR_W = (MAX_IDS > 1) ? $clog2(MAX_IDS) : 1;
  localparam int CAP   = (MAX_IDS < ID_SPACE) ? MAX_IDS : ID_SPACE;
  localparam logic [CNT_W-1:0] CAP_CNT    = CNT_W'(CAP);
  localparam logic [PTR_W-1:0] PTR_LAST   = PTR_W'(MAX_IDS - 1);
  localparam logic [ID_W-1:0]  SWEEP_LAST = ID_W'(ID_SPACE - 1);

  fipa_state_t        state_r, state_nxt;
  logic [PTR_W-1:0]   head_r, head_nxt;
  logic [PTR_W-1:0]   tail_r, tail_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CNT_W-1:0]   init_n_r, init_n_nxt;
  logic [ID_W-1:0]    sweep_r, sweep_nxt;
  logic [ID_W-1:0]    rel_id_r, rel_id_nxt;
  logic [CNT_W-1:0]   pool_size_r;
  logic               out_valid_r, out_valid_nxt;
  fipa_out_t          out_data_r, out_data_nxt;

  logic               in_fire;
  logic [CNT_W-1:0]   load_n;
  logic [CNT_W-1:0]   count_inc;
  logic               rel_ok;
  logic               fill;
  logic               sweep_done;
  logic [PTR_W-1:0]   head_adv, tail_adv;

  logic               ring_we, ring_re;
  logic [PTR_W-1:0]   ring_waddr;
  logic [ID_W-1:0]    ring_wdata;
  logic [ID_W-1:0]    ring_rdata;

  fipa_bm_ctrl_t      bm_ctrl;
  logic               bm_re;
  logic               bm_hit;

  fipa_ring #(
    .DEPTH (MAX_IDS)
  ) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (ring_waddr),
    .wdata (ring_wdata),
    .re    (ring_re),
    .raddr (head_r),
    .rdata (ring_rdata)
  );

  fipa_bitmap u_bitmap (
    .clk    (clk),
    .ctrl   (bm_ctrl),
    .rd_en  (bm_re),
    .rd_id  (in_data.id_in),
    .rd_hit (bm_hit)
  );

  // Handshake and shared terms
  assign in_ready   = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign in_fire    = in_valid && in_ready;
  assign load_n     = (pool_size_r > CAP_CNT) ? CAP_CNT : pool_size_r;
  assign count_inc  = count_r + CNT_W'(1);
  assign rel_ok     = !bm_hit && (count_r < CAP_CNT);
  assign fill       = CNT_W'(sweep_r) < init_n_r;
  assign sweep_done = (sweep_r == SWEEP_LAST);
  assign head_adv   = (head_r == PTR_LAST) ? '0 : head_r + PTR_W'(1);
  assign tail_adv   = (tail_r == PTR_LAST) ? '0 : tail_r + PTR_W'(1);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if ((in_data.command == CMD_ALLOC) && (count_r != '0)) begin
            state_nxt = ST_ALLOC_RD;
          end else if (in_data.command == CMD_RELEASE) begin
            state_nxt = ST_REL_CHK;
          end else if (in_data.command == CMD_REINIT) begin
            state_nxt = ST_INIT;
          end
        end
      end
      ST_ALLOC_RD: begin
        state_nxt = ST_IDLE;
      end
      ST_REL_CHK: begin
        state_nxt = ST_IDLE;
      end
      ST_INIT, ST_WIPE: begin
        if (sweep_done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Datapath and result. Ring and bitmap writes of an item land at its last
  // edge and the next item reads at a later accept edge, so one item at a
  // time serves as the interlock on both memories.
  always_comb begin
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    count_nxt     = count_r;
    init_n_nxt    = init_n_r;
    sweep_nxt     = sweep_r;
    rel_id_nxt    = rel_id_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    ring_we       = 1'b0;
    ring_re       = 1'b0;
    ring_waddr    = tail_r;
    ring_wdata    = rel_id_r;
    bm_ctrl       = '0;
    bm_re         = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          out_data_nxt = '0;
          case (in_data.command)
            CMD_ALLOC: begin
              if (count_r != '0) begin
                ring_re   = 1'b1;
                head_nxt  = head_adv;
                count_nxt = count_r - CNT_W'(1);
              end else begin
                out_valid_nxt = 1'b1;
              end
            end
            CMD_RELEASE: begin
              // Look up the presence flag, decide next cycle
              bm_re      = 1'b1;
              rel_id_nxt = in_data.id_in;
            end
            CMD_REINIT: begin
              head_nxt   = '0;
              tail_nxt   = '0;
              count_nxt  = '0;
              init_n_nxt = load_n;
              sweep_nxt  = '0;
            end
            default: begin
              out_valid_nxt          = 1'b1;
              out_data_nxt.free_left = count_r;
            end
          endcase
        end
      end
      ST_ALLOC_RD: begin
        out_valid_nxt          = 1'b1;
        out_data_nxt           = '0;
        out_data_nxt.alloc_valid = 1'b1;
        out_data_nxt.alloc_id  = ring_rdata;
        out_data_nxt.free_left = count_r;
        bm_ctrl.wr_en          = 1'b1;
        bm_ctrl.wr_id          = ring_rdata;
        bm_ctrl.wr_bit         = 1'b0;
      end
      ST_REL_CHK: begin
        out_valid_nxt                 = 1'b1;
        out_data_nxt                  = '0;
        out_data_nxt.release_accepted = rel_ok;
        out_data_nxt.free_left        = count_r;
        if (rel_ok) begin
          ring_we                = 1'b1;
          tail_nxt               = tail_adv;
          count_nxt              = count_inc;
          bm_ctrl.wr_en          = 1'b1;
          bm_ctrl.wr_id          = rel_id_r;
          bm_ctrl.wr_bit         = 1'b1;
          out_data_nxt.free_left = count_inc;
        end
      end
      ST_INIT, ST_WIPE: begin
        // Rewrite one flag a cycle; queue identifiers below the load count
        bm_ctrl.wr_en  = 1'b1;
        bm_ctrl.wr_id  = sweep_r;
        bm_ctrl.wr_bit = fill;
        sweep_nxt      = sweep_r + ID_W'(1);
        if (fill) begin
          ring_we    = 1'b1;
          ring_wdata = sweep_r;
          tail_nxt   = tail_adv;
          count_nxt  = count_inc;
        end
        if ((state_r == ST_INIT) && sweep_done) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt           = '0;
          out_data_nxt.free_left = fill ? count_inc : count_r;
        end
      end
      default: begin
        out_valid_nxt = out_valid_r && !out_ready;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_WIPE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      init_n_r    <= '0;
      sweep_r     <= '0;
      rel_id_r    <= '0;
      out_valid_r <= 1'b0;
      pool_size_r <= CNT_W'(ID_SPACE);
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      init_n_r    <= init_n_nxt;
      sweep_r     <= sweep_nxt;
      rel_id_r    <= rel_id_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        pool_size_r <= cfg_wdata;
      end
    end
  end

  // Hold the output beat
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_CNT)
    else $error("free count above pool capacity");

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (state_r == ST_IDLE))
    else $error("input taken while an item is in flight");

  a_sweep_no_out: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_INIT) || (state_r == ST_WIPE)) |-> !out_valid_r)
    else $error("output beat pending during bitmap sweep");

  a_alloc_read: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_data.command == CMD_ALLOC) && (count_r != '0))
      |=> ((state_r == ST_ALLOC_RD) && !out_valid_r))
    else $error("allocate read not followed by data cycle");

  a_alloc_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ALLOC_RD) |=> (out_valid_r && out_data_r.alloc_valid))
    else $error("allocate result missing");

  a_rel_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_REL_CHK) |=> out_valid_r)
    else $error("release result missing");
`endif

endmodule : free_id_pool_allocator
`default_nettype wire
